// ===== hdl/tds_pkg.sv =====
`default_nettype none

package tds_pkg;

    // name store sizing; the length field covers the whole legal parameter range
    localparam int NAME_MAX_DEF = 64;
    localparam int NAME_MAX_HI  = 64;
    localparam int LEN_W        = $clog2(NAME_MAX_HI + 1);
    localparam int IDX_W        = $clog2(NAME_MAX_HI);

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam int         NUM_PFX  = 4;
    localparam int         COL_W    = 4;
    localparam int         PFX_COLS = 2 ** COL_W;
    localparam logic [COL_W-1:0] COL_SAT = '1;

    // prefixes: test( and check(, then both again behind module_
    localparam logic [7:0] PFX_TEXT [NUM_PFX][PFX_COLS] = '{
        '{"t", "e", "s", "t", "(", 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "h", "e", "c", "k", "(", 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "o", "d", "u", "l", "e", "_", "t",
          "e", "s", "t", "(", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "o", "d", "u", "l", "e", "_", "c",
          "h", "e", "c", "k", "(", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [COL_W-1:0] PFX_LEN [NUM_PFX] = '{4'd5, 4'd6, 4'd12, 4'd13};
    localparam logic             PFX_KIND [NUM_PFX] = '{1'b0, 1'b0, 1'b1, 1'b1};

    // extraction command, front to back
    typedef struct packed {
        logic             missing;
        logic             empty;
        logic             kind;
        logic             ovf;
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // name store write, front to back
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } t_wr;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/tds_if.sv =====
`default_nettype none

interface tds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       new_file;

    modport source (output valid, output char_in, output new_file, input ready);
    modport sink   (input valid, input char_in, input new_file, output ready);
endinterface

interface tds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       case_kind;
    logic       last_of_name;
    logic       empty_name;
    logic       truncated;
    logic       missing_close;

    modport source (output valid, output name_char, output case_kind, output last_of_name,
                    output empty_name, output truncated, output missing_close,
                    input ready);
    modport sink   (input valid, input name_char, input case_kind, input last_of_name,
                    input empty_name, input truncated, input missing_close,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/tds_front.sv =====
`default_nettype none

module tds_front #(
    parameter int NAME_MAX = tds_pkg::NAME_MAX_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tds_in_if.sink       i_in,
    input  wire logic    i_done,
    output tds_pkg::t_cmd o_cmd,
    output logic         o_push,
    output tds_pkg::t_wr o_wr
);
    import tds_pkg::*;

    localparam int LW = $clog2(NAME_MAX + 1);

    logic             r_blk, r_row, r_body, r_seen, r_halt, r_bank;
    logic [7:0]       r_prev;
    logic [COL_W-1:0] r_col;
    logic [NUM_PFX-1:0] r_pfx;
    logic [LW-1:0]    r_len;
    logic             r_closed, r_ovf, r_cut;
    logic [1:0]       r_cnt;

    logic             n_blk, n_row, n_body, n_seen, n_halt, n_bank;
    logic [7:0]       n_prev;
    logic [COL_W-1:0] n_col;
    logic [NUM_PFX-1:0] n_pfx;
    logic [LW-1:0]    n_len;
    logic             n_closed, n_ovf, n_cut;
    logic [1:0]       n_cnt;

    // {hit, index} of the first fully matched prefix
    function automatic logic [2:0] pfx_hit(logic [NUM_PFX-1:0] pfx, logic [COL_W-1:0] col);
        logic [2:0] res;
        res = '0;
        for (int k = NUM_PFX - 1; k >= 0; k--) begin
            if (pfx[k] && col >= PFX_LEN[k]) begin
                res = {1'b1, 2'(k)};
            end
        end
        return res;
    endfunction

    assign i_in.ready = (r_cnt != 2'd2);

    always_comb begin
        logic             acc, nf;
        logic [7:0]       c;
        logic             e_blk, e_row, e_body, e_seen, e_halt;
        logic [7:0]       e_prev;
        logic [COL_W-1:0] e_col;
        logic [NUM_PFX-1:0] e_pfx;
        logic [LW-1:0]    e_len;
        logic             e_closed, e_ovf, e_cut;
        logic             blk_start, blk_end, bc_start, bc_end, rc_start, rc_end, eod;
        logic             body_v, blk_v, row_v, seen_v, stop;
        logic [2:0]       m, m2;
        logic [COL_W-1:0] l_col;
        logic [NUM_PFX-1:0] l_pfx;
        logic [LW-1:0]    l_len;
        logic             l_closed, l_ovf, l_cut;

        acc = i_in.valid && i_in.ready;
        nf  = i_in.new_file;
        c   = i_in.char_in;

        n_blk = r_blk; n_row = r_row; n_body = r_body; n_seen = r_seen;
        n_halt = r_halt; n_bank = r_bank; n_prev = r_prev;
        n_col = r_col; n_pfx = r_pfx; n_len = r_len;
        n_closed = r_closed; n_ovf = r_ovf; n_cut = r_cut;
        o_push = 1'b0;
        o_cmd  = '0;
        o_wr   = '0;

        // new_file applies reset values before this byte
        e_blk    = nf ? 1'b0 : r_blk;
        e_row    = nf ? 1'b0 : r_row;
        e_body   = nf ? 1'b0 : r_body;
        e_seen   = nf ? 1'b0 : r_seen;
        e_halt   = nf ? 1'b0 : r_halt;
        e_prev   = nf ? 8'h00 : r_prev;
        e_col    = nf ? '0 : r_col;
        e_pfx    = nf ? '1 : r_pfx;
        e_len    = nf ? '0 : r_len;
        e_closed = nf ? 1'b0 : r_closed;
        e_ovf    = nf ? 1'b0 : r_ovf;
        e_cut    = nf ? 1'b0 : r_cut;

        blk_start = !e_body && !e_seen && c == CH_LBRACE;
        blk_end   = e_body && !e_seen && c == CH_RBRACE;
        bc_start  = !e_body && e_prev == CH_SLASH && c == CH_STAR;
        bc_end    = !e_body && e_prev == CH_STAR && c == CH_SLASH;
        rc_start  = !e_body && e_prev == CH_SLASH && c == CH_SLASH;
        rc_end    = e_row && !e_body && c == CH_NL;
        eod       = !e_body && !e_seen && (c == CH_NL || c == CH_LBRACE);
        body_v    = e_body | blk_start;
        blk_v     = e_blk | bc_start;
        row_v     = e_row | rc_start;
        seen_v    = blk_v | row_v;
        m         = pfx_hit(e_pfx, e_col);
        stop      = 1'b0;

        l_col = e_col; l_pfx = e_pfx; l_len = e_len;
        l_closed = e_closed; l_ovf = e_ovf; l_cut = e_cut;
        m2 = '0;

        if (acc) begin
            n_blk = e_blk; n_row = e_row; n_body = e_body; n_seen = e_seen;
            n_halt = e_halt; n_prev = e_prev;
            n_col = e_col; n_pfx = e_pfx; n_len = e_len;
            n_closed = e_closed; n_ovf = e_ovf; n_cut = e_cut;
            if (!e_halt) begin
                if (eod && m[2]) begin
                    o_push        = 1'b1;
                    o_cmd.missing = !e_closed;
                    o_cmd.empty   = e_closed && (e_len == '0);
                    o_cmd.kind    = e_closed ? PFX_KIND[m[1:0]] : 1'b0;
                    o_cmd.ovf     = e_closed ? e_ovf : 1'b0;
                    o_cmd.bank    = r_bank;
                    o_cmd.len     = LEN_W'(e_len);
                    if (!e_closed) begin
                        // unterminated name: halt until new_file or reset
                        n_halt = 1'b1;
                        n_body = body_v;
                        n_blk  = blk_v;
                        n_row  = row_v;
                        n_seen = seen_v;
                        stop   = 1'b1;
                    end else begin
                        n_bank = ~r_bank;
                    end
                end
                if (!stop) begin
                    if (eod || c == CH_NL) begin
                        l_col = '0; l_pfx = '1; l_len = '0;
                        l_closed = 1'b0; l_ovf = 1'b0; l_cut = 1'b0;
                    end
                    if (c != CH_NL) begin
                        m2 = pfx_hit(l_pfx, l_col);
                        if (m2[2]) begin
                            if (!l_closed) begin
                                if (c == CH_RPAREN) begin
                                    l_closed = 1'b1;
                                end else if (c == CH_NUL) begin
                                    l_cut = 1'b1;
                                end else if (!l_cut) begin
                                    if (l_len < LW'(NAME_MAX)) begin
                                        o_wr.en   = 1'b1;
                                        o_wr.bank = r_bank;
                                        o_wr.idx  = IDX_W'(l_len);
                                        o_wr.data = c;
                                        l_len     = l_len + LW'(1);
                                    end else begin
                                        l_ovf = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            for (int k = 0; k < NUM_PFX; k++) begin
                                if (l_pfx[k] && l_col < PFX_LEN[k] &&
                                    c != PFX_TEXT[k][l_col]) begin
                                    l_pfx[k] = 1'b0;
                                end
                            end
                        end
                        if (l_col != COL_SAT) begin
                            l_col = l_col + COL_W'(1);
                        end
                    end
                    n_col = l_col; n_pfx = l_pfx; n_len = l_len;
                    n_closed = l_closed; n_ovf = l_ovf; n_cut = l_cut;
                    n_blk  = blk_v & ~bc_end;
                    n_row  = row_v & ~rc_end;
                    n_body = body_v & ~blk_end;
                    n_seen = seen_v;
                    n_prev = c;
                end
            end
        end

        n_cnt = r_cnt + {1'b0, o_push} - {1'b0, i_done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk    <= 1'b0;
            r_row    <= 1'b0;
            r_body   <= 1'b0;
            r_seen   <= 1'b0;
            r_halt   <= 1'b0;
            r_bank   <= 1'b0;
            r_prev   <= 8'h00;
            r_col    <= '0;
            r_pfx    <= '1;
            r_len    <= '0;
            r_closed <= 1'b0;
            r_ovf    <= 1'b0;
            r_cut    <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_blk    <= n_blk;
            r_row    <= n_row;
            r_body   <= n_body;
            r_seen   <= n_seen;
            r_halt   <= n_halt;
            r_bank   <= n_bank;
            r_prev   <= n_prev;
            r_col    <= n_col;
            r_pfx    <= n_pfx;
            r_len    <= n_len;
            r_closed <= n_closed;
            r_ovf    <= n_ovf;
            r_cut    <= n_cut;
            r_cnt    <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tds_queue.sv =====
`default_nettype none

module tds_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tds_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output tds_pkg::t_cmd      o_cmd,
    output logic               o_valid,
    output logic               o_full
);
    import tds_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_cmd   = r_slot[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tds_back.sv =====
`default_nettype none

module tds_back #(
    parameter int NAME_MAX = tds_pkg::NAME_MAX_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tds_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_pop,
    input  wire tds_pkg::t_wr  i_wr,
    output logic               o_done,
    tds_out_if.source          o_out
);
    import tds_pkg::*;

    localparam int AW = $clog2(NAME_MAX);

    // two banks: front fills one while the other is read out
    logic [7:0]  r_name_mem [2][NAME_MAX];
    logic [7:0]  r_rd_data;

    t_back_state r_state, n_state;
    t_cmd        r_cur, n_cur;
    logic [AW-1:0] r_idx, n_idx;

    logic        r_ov, n_ov;
    logic [7:0]  r_name_char, n_name_char;
    logic        r_kind, n_kind, r_last, n_last, r_empty, n_empty;
    logic        r_trunc, n_trunc, r_miss, n_miss;

    assign o_out.valid         = r_ov;
    assign o_out.name_char     = r_name_char;
    assign o_out.case_kind     = r_kind;
    assign o_out.last_of_name  = r_last;
    assign o_out.empty_name    = r_empty;
    assign o_out.truncated     = r_trunc;
    assign o_out.missing_close = r_miss;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_name_mem[i_wr.bank][i_wr.idx[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_name_mem[r_cur.bank][r_idx];
    end

    always_comb begin
        logic out_free, load, last;

        out_free = !r_ov || o_out.ready;
        load     = 1'b0;
        last     = (LEN_W'(r_idx) + LEN_W'(1) == r_cur.len);

        n_state = r_state;
        n_cur   = r_cur;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        o_done  = 1'b0;
        n_name_char = r_name_char;
        n_kind  = r_kind;
        n_last  = r_last;
        n_empty = r_empty;
        n_trunc = r_trunc;
        n_miss  = r_miss;

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.missing || i_cmd.empty) begin
                        // single-beat result
                        if (out_free) begin
                            load        = 1'b1;
                            o_pop       = 1'b1;
                            o_done      = 1'b1;
                            n_name_char = 8'h00;
                            n_kind      = i_cmd.kind;
                            n_last      = 1'b1;
                            n_empty     = i_cmd.empty;
                            n_trunc     = 1'b0;
                            n_miss      = i_cmd.missing;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_cur   = i_cmd;
                        n_idx   = '0;
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                if (out_free) begin
                    load        = 1'b1;
                    n_name_char = r_rd_data;
                    n_kind      = r_cur.kind;
                    n_last      = last;
                    n_empty     = 1'b0;
                    n_trunc     = r_cur.ovf;
                    n_miss      = 1'b0;
                    if (last) begin
                        o_done  = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (load) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_idx       <= n_idx;
        r_name_char <= n_name_char;
        r_kind      <= n_kind;
        r_last      <= n_last;
        r_empty     <= n_empty;
        r_trunc     <= n_trunc;
        r_miss      <= n_miss;
    end

endmodule

`default_nettype wire

// ===== hdl/test_declaration_scanner_top.sv =====
// Channel | Dir | Payload                                              | Beat
// i_in    | in  | char_in[7:0], new_file                               | one source byte
// o_out   | out | name_char[7:0], case_kind, last_of_name, empty_name, | one result
//         |     | truncated, missing_close                             |
//
// Scanning runs at one byte per cycle; no result is caused by most bytes.
// Name beats pass the read and load states, set by the registered read of
// the banked name store. Input stalls only while two extractions are pending.
// Reset is synchronous, active low; the name store needs no clearing pass.
// Either side may stall at any time; the output register holds its beat.
`default_nettype none

module test_declaration_scanner_top #(
    parameter int NAME_MAX = tds_pkg::NAME_MAX_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tds_in_if.sink    i_in,
    tds_out_if.source o_out
);
    import tds_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    t_wr  store_wr;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    logic done;

    // front: comment/body tracking, prefix match, name capture
    tds_front #(
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_done  (done),
        .o_cmd   (front_cmd),
        .o_push  (push),
        .o_wr    (store_wr)
    );

    // short command queue between front and back
    tds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // back: name store readout and output register
    tds_back #(
        .NAME_MAX (NAME_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_pop       (pop),
        .i_wr        (store_wr),
        .o_done      (done),
        .o_out       (o_out)
    );

    // queue never overflows: the front throttles on outstanding extractions
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!q_full || pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("command queue underflow");

    // error beat is a lone, blank, final beat
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.missing_close) |->
            (o_out.last_of_name && o_out.name_char == 8'h00 && !o_out.case_kind &&
             !o_out.empty_name && !o_out.truncated))
        else $error("malformed missing-close beat");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.empty_name) |->
            (o_out.last_of_name && o_out.name_char == 8'h00))
        else $error("malformed empty-name beat");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tds_pkg::*;

    // prefix codes, in the order they are tried
    typedef enum int {
        PX_TEST,
        PX_CHECK,
        PX_MOD_TEST,
        PX_MOD_CHECK
    } t_prefix;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    localparam logic KIND_UNIT   = 1'b0;
    localparam logic KIND_MODULE = 1'b1;

    localparam int NAME_CAP     = NAME_MAX_DEF;
    localparam int COL_TOP      = 15;       // column counter saturates here
    localparam int RANDOM_BYTES = 460;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 40;       // drain time after the last expected beat
    localparam int HOLD_AFTER   = 4;        // output beats before the long receiver hold
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       new_file;
    } t_src_byte;

    typedef struct packed {
        logic [7:0] name_char;
        logic       case_kind;
        logic       last_of_name;
        logic       empty_name;
        logic       truncated;
        logic       missing_close;
    } t_name_beat;

    logic clk;
    logic rst_n;

    tds_in_if  in_bus ();
    tds_out_if out_bus ();

    test_declaration_scanner_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    t_src_byte  src_bytes [$];     // source text still to be offered
    t_name_beat names_due [$];     // name beats the scanner still owes us
    int         mismatches = 0;
    int         cycles = 0;

    // ------------------------------------------------------------------
    // Scanner predictor: own copy of the scan state
    // ------------------------------------------------------------------
    logic       sc_block_cmt, sc_row_cmt, sc_body, sc_cmt_seen, sc_halt;
    logic [7:0] sc_prev;
    logic [3:0] sc_col;
    logic [3:0] sc_pfx;            // one bit per prefix that can still match
    logic [7:0] sc_name [NAME_CAP];
    int         sc_len;
    logic       sc_closed, sc_ovf, sc_cut;

    function automatic string prefix_text(input int k);
        string mod_pfx;
        mod_pfx = "module_";
        case (k)
            PX_TEST:     return "test(";
            PX_CHECK:    return "check(";
            PX_MOD_TEST: return {mod_pfx, "test("};
            default:     return {mod_pfx, "check("};
        endcase
    endfunction

    function automatic t_name_beat beat(input logic [7:0] ch, input logic kind,
                                        input logic last, input logic empty,
                                        input logic trunc, input logic miss);
        t_name_beat b;
        b.name_char     = ch;
        b.case_kind     = kind;
        b.last_of_name  = last;
        b.empty_name    = empty;
        b.truncated     = trunc;
        b.missing_close = miss;
        return b;
    endfunction

    task automatic line_clear();
        sc_col    = '0;
        sc_pfx    = 4'hF;
        sc_len    = 0;
        sc_closed = 1'b0;
        sc_ovf    = 1'b0;
        sc_cut    = 1'b0;
    endtask

    task automatic scan_reset();
        sc_block_cmt = 1'b0;
        sc_row_cmt   = 1'b0;
        sc_body      = 1'b0;
        sc_prev      = '0;
        sc_cmt_seen  = 1'b0;
        sc_halt      = 1'b0;
        for (int i = 0; i < NAME_CAP; i++) sc_name[i] = '0;
        line_clear();
    endtask

    // first prefix that has fully matched on this line, -1 if none
    function automatic int prefix_hit();
        string p;
        for (int k = 0; k < 4; k++) begin
            p = prefix_text(k);
            if (sc_pfx[k] && int'(sc_col) >= p.len()) return k;
        end
        return -1;
    endfunction

    task automatic line_push(input logic [7:0] c);
        int    m;
        string p;
        m = prefix_hit();
        if (m >= 0) begin
            if (!sc_closed) begin
                if (c == CH_RPAREN) begin
                    sc_closed = 1'b1;
                end else if (c == CH_NUL) begin
                    sc_cut = 1'b1;          // name ends at a zero byte
                end else if (!sc_cut) begin
                    if (sc_len < NAME_CAP) begin
                        sc_name[sc_len] = c;
                        sc_len++;
                    end else begin
                        sc_ovf = 1'b1;
                    end
                end
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                p = prefix_text(k);
                if (sc_pfx[k] && int'(sc_col) < p.len() && c != p[int'(sc_col)])
                    sc_pfx[k] = 1'b0;
            end
        end
        if (int'(sc_col) < COL_TOP) sc_col++;
    endtask

    // line ends outside body and comment: emit the declared name, if any
    task automatic emit_line();
        int   m;
        logic kind;
        m = prefix_hit();
        if (m < 0) return;
        kind = (m == PX_MOD_TEST || m == PX_MOD_CHECK) ? KIND_MODULE : KIND_UNIT;
        if (!sc_closed) begin
            names_due.push_back(beat(8'h00, KIND_UNIT, 1'b1, 1'b0, 1'b0, 1'b1));
            sc_halt = 1'b1;
        end else if (sc_len == 0) begin
            names_due.push_back(beat(8'h00, kind, 1'b1, 1'b1, 1'b0, 1'b0));
        end else begin
            for (int i = 0; i < sc_len; i++)
                names_due.push_back(beat(sc_name[i], kind, (i + 1 == sc_len),
                                         1'b0, sc_ovf, 1'b0));
        end
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic nf);
        logic [7:0] lc;
        logic       cm, blk_start, blk_end, bc_start, bc_end, rc_start, rc_end, eod;
        if (nf) scan_reset();
        if (sc_halt) return;

        lc = sc_prev;
        cm = sc_cmt_seen;   // comment flags as of the previous byte
        blk_start = !sc_body && !cm && c == CH_LBRACE;
        blk_end   = sc_body && !cm && c == CH_RBRACE;
        bc_start  = !sc_body && lc == CH_SLASH && c == CH_STAR;
        bc_end    = !sc_body && lc == CH_STAR && c == CH_SLASH;
        rc_start  = !sc_body && lc == CH_SLASH && c == CH_SLASH;
        rc_end    = sc_row_cmt && !sc_body && c == CH_NL;
        eod       = !sc_body && !cm && (c == CH_NL || c == CH_LBRACE);

        if (blk_start) sc_body = 1'b1;
        if (bc_start) sc_block_cmt = 1'b1;
        if (rc_start) sc_row_cmt = 1'b1;
        sc_cmt_seen = sc_block_cmt || sc_row_cmt;

        if (eod) begin
            emit_line();
            if (sc_halt) return;
            line_clear();
        end
        // a brace that ended the line opens the next one
        if (c == CH_NL) line_clear();
        else line_push(c);

        if (bc_end) sc_block_cmt = 1'b0;
        if (rc_end) sc_row_cmt = 1'b0;
        if (blk_end) sc_body = 1'b0;
        sc_prev = c;
    endtask

    // ------------------------------------------------------------------
    // Source text generation
    // ------------------------------------------------------------------
    int   n_items = 0;
    logic file_start = 1'b1;   // next byte carries new_file
    logic long_seen = 1'b0;

    task automatic put_byte(input logic [7:0] c);
        t_src_byte s;
        s.ch       = c;
        s.new_file = file_start;
        file_start = 1'b0;
        src_bytes.push_back(s);
        n_items++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    function automatic logic [7:0] ident_char();
        string s = "abcdefghijklmnopqrstuvwxyz_0123456789QXZ";
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // mostly identifiers, now and then a zero byte or any byte at all
    function automatic logic [7:0] name_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 8'($urandom_range(0, 255));
        if (r < 5) return CH_NUL;
        return ident_char();
    endfunction

    task automatic body_text();
        int n, r;
        n = $urandom_range(0, 16);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            case (r)
                0:       put_byte(CH_NL);
                1:       put_byte(CH_SLASH);
                2:       put_byte(CH_STAR);
                3:       put_byte(CH_LBRACE);
                4:       put_byte(CH_RPAREN);
                5:       put_text(" ");
                6:       put_text("test(inner)\n");   // must not extract inside a body
                default: put_byte(ident_char());
            endcase
        end
    endtask

    task automatic gen_decl(input logic force_long);
        int         k, n, r, bad_at;
        string      p;
        logic [7:0] b;
        k = $urandom_range(0, 3);
        p = prefix_text(k);
        if ($urandom_range(0, 11) == 0) put_text(" ");
        bad_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, p.len() - 1) : -1;
        for (int i = 0; i < p.len(); i++) begin
            b = p[i];
            if (i == bad_at) b = 8'($urandom_range(0, 255));
            put_byte(b);
        end
        r = $urandom_range(0, 99);
        if (force_long || (r >= 15 && r < 25)) n = $urandom_range(62, 72);
        else if (r < 15) n = 0;
        else n = $urandom_range(1, 12);
        if (n > NAME_CAP) long_seen = 1'b1;
        for (int i = 0; i < n; i++) put_byte(name_byte());
        if ($urandom_range(0, 15) != 0) put_byte(CH_RPAREN);
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) put_byte(ident_char());
        end
        // end the line with a newline or open a body right after it
        if ($urandom_range(0, 9) < 6) begin
            put_byte(CH_NL);
        end else begin
            put_text(" ");
            put_byte(CH_LBRACE);
            body_text();
            put_byte(CH_RBRACE);
            put_byte(CH_NL);
        end
    endtask

    task automatic gen_line();
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            gen_decl(!long_seen && n_items > 300);
        end else if (r < 70) begin
            // block comment, sometimes with a declaration glued right after it
            put_byte(CH_SLASH);
            put_byte(CH_STAR);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                put_byte(($urandom_range(0, 7) == 0) ? CH_NL : ident_char());
            put_byte(CH_STAR);
            put_byte(CH_SLASH);
            if ($urandom_range(0, 1) == 0) put_byte(CH_NL);
            else gen_decl(1'b0);
        end else if (r < 78) begin
            put_byte(CH_SLASH);
            put_byte(CH_SLASH);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                put_byte(($urandom_range(0, 3) == 0) ? CH_SLASH : ident_char());
            put_byte(CH_NL);
        end else if (r < 88) begin
            // raw noise covers every byte value
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
            put_byte(CH_NL);
        end else begin
            put_byte(CH_LBRACE);
            body_text();
            put_byte(CH_RBRACE);
            put_byte(CH_NL);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps
    // ------------------------------------------------------------------
    int   burst_left = 1;
    int   gap_left = 0;
    logic in_took;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            in_took = in_bus.valid && in_bus.ready;
            if (in_took) begin
                scan_byte(src_bytes[0].ch, src_bytes[0].new_file);
                void'(src_bytes.pop_front());
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            // a beat on offer stays put until it is taken
            if (!in_bus.valid || in_took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_bus.valid <= 1'b0;
                end else if (src_bytes.size() > 0) begin
                    in_bus.valid    <= 1'b1;
                    in_bus.char_in  <= src_bytes[0].ch;
                    in_bus.new_file <= src_bytes[0].new_file;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall patterns plus one long hold so that
    // extractions pile up inside the block and it backs up its input
    // ------------------------------------------------------------------
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_beats = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    logic     rx_rdy;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) rx_beats++;
            if (!hold_done && rx_beats >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 120);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_rdy = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rx_rdy = 1'b1;
                    RX_HALF:   rx_rdy = $urandom_range(0, 1);
                    RX_SPARSE: rx_rdy = ($urandom_range(0, 3) == 0);
                    default:   rx_rdy = !out_bus.ready;
                endcase
            end
            out_bus.ready <= rx_rdy;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checking
    // ------------------------------------------------------------------
    function automatic string beat_str(input t_name_beat b);
        return $sformatf("ch=%02h kind=%0b last=%0b empty=%0b trunc=%0b miss=%0b",
                         b.name_char, b.case_kind, b.last_of_name, b.empty_name,
                         b.truncated, b.missing_close);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) $display("cycle %0d: %s", cycles, msg);
    endtask

    t_name_beat got_beat, want_beat;

    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            got_beat = beat(out_bus.name_char, out_bus.case_kind, out_bus.last_of_name,
                            out_bus.empty_name, out_bus.truncated, out_bus.missing_close);
            if (names_due.size() == 0) begin
                flag_mismatch({"unexpected beat ", beat_str(got_beat)});
            end else begin
                want_beat = names_due.pop_front();
                if (got_beat !== want_beat)
                    flag_mismatch({"got ", beat_str(got_beat),
                                   " want ", beat_str(want_beat)});
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    int dir_items;

    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_bus.valid    = 1'b0;
        in_bus.char_in  = '0;
        in_bus.new_file = 1'b0;
        out_bus.ready   = 1'b0;
        scan_reset();

        // directed: empty name, zero byte cutting the name, missing ')'
        // with a halted byte, then a new file starting on a zero byte
        put_text("test()");
        put_byte(CH_NL);
        put_text("check(");
        put_byte(CH_NUL);
        put_text("z)");
        put_byte(CH_NL);
        put_text("test(a");
        put_byte(CH_NL);
        put_byte(8'hFF);
        file_start = 1'b1;
        put_byte(CH_NUL);
        dir_items = n_items;

        // random files of a few lines each; every file starts clean
        while (n_items < dir_items + RANDOM_BYTES) begin
            file_start = 1'b1;
            repeat ($urandom_range(1, 6)) gen_line();
            // last line left open: never tested
            if ($urandom_range(0, 7) == 0) put_text("check(tail)");
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (src_bytes.size() != 0 || names_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
